/* design/gts_pkg.sv */
// Shared types and constants for the grouped topological sorter.
`timescale 1ns / 1ps

package gts_pkg;

    localparam int MAX_ITEMS  = 64;
    localparam int MAX_GROUPS = 64;
    localparam int MAX_EDGES  = 256;
    localparam int SLOTS      = MAX_ITEMS + MAX_GROUPS;

    localparam int ITEM_W  = $clog2(MAX_ITEMS);
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CFG_W   = 7;
    localparam int CNT_W   = SLOT_W + 1;
    localparam int EADDR_W = $clog2(MAX_EDGES);
    localparam int ECNT_W  = EADDR_W + 1;
    localparam int DEG_W   = ECNT_W;
    localparam int EDGE_W  = 2 * ITEM_W;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 8;

    // Configuration register indexes
    localparam logic CFG_ITEM_COUNT  = 1'b0;
    localparam logic CFG_GROUP_COUNT = 1'b1;

    typedef enum logic [1:0] {
        OP_CLEAR     = 2'd0,
        OP_SET_GROUP = 2'd1,
        OP_ADD_EDGE  = 2'd2,
        OP_START     = 2'd3
    } t_op;

    typedef enum logic [5:0] {
        S_IDLE, S_INIT, S_CLR, S_GID_RD, S_GID_WR,
        S_DEG_E, S_DEG_G, S_DEG_R, S_DEG_W,
        S_GS_RD, S_GS_CK, S_GPOP, S_GTAKE,
        S_GE, S_GE_G, S_GE_R, S_GE_W, S_GCHK,
        S_KRD, S_KSET, S_IS_RD, S_IS_CK, S_IPOP, S_ITAKE,
        S_IE, S_IE_G, S_IE_R, S_IE_W, S_ICHK,
        S_EMIT_RD, S_EMIT, S_FAIL
    } t_state;

    typedef enum logic [5:0] {
        C_NONE, C_INIT, C_CLR, C_GID_RD, C_GID_WR,
        C_DEG_E, C_DEG_G, C_DEG_R, C_DEG_W,
        C_GS_RD, C_GS_CK, C_GPOP, C_GTAKE,
        C_GE, C_GE_G, C_GE_R, C_GE_W,
        C_GCHK, C_KRD, C_KSET, C_IS_RD, C_IS_CK, C_IPOP, C_ITAKE,
        C_IE, C_IE_G, C_IE_R, C_IE_W, C_ICHK,
        C_EMIT_RD, C_EMIT, C_FAIL
    } t_cmd;

    typedef struct packed {
        t_cmd op;
        logic load;
    } t_ctrl;

    typedef struct packed {
        logic e_done;
        logic clr_last;
        logic gid_last;
        logic i_eq_total;
        logic i_eq_n;
        logic q_empty;
        logic range_skip;
        logic grp_skip;
        logic it_skip;
        logic gid_b_ne_g;
        logic cnt_ok_total;
        logic cnt_ok_members;
        logic k_done;
        logic out_busy;
        logic emit_last;
    } t_status;

endpackage

/* design/gts_ctrl.sv */
// Sequencer that steps the datapath through load, clear, count, order and emit.
`timescale 1ns / 1ps

module gts_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [1:0]      i_opcode,
    input  gts_pkg::t_status i_stat,
    output logic            o_ready,
    output gts_pkg::t_ctrl  o_ctrl
);
    import gts_pkg::*;

    t_state r_state, n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Pick next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_valid && (i_opcode == OP_START)) n_state = S_INIT;
            S_INIT:    n_state = S_CLR;
            S_CLR:     if (i_stat.clr_last) n_state = S_GID_RD;
            S_GID_RD:  n_state = S_GID_WR;
            S_GID_WR:  n_state = i_stat.gid_last ? S_DEG_E : S_GID_RD;
            S_DEG_E:   n_state = i_stat.e_done ? S_GS_RD : S_DEG_G;
            S_DEG_G:   n_state = i_stat.range_skip ? S_DEG_E : S_DEG_R;
            S_DEG_R:   n_state = S_DEG_W;
            S_DEG_W:   n_state = S_DEG_E;
            S_GS_RD:   n_state = i_stat.i_eq_total ? S_GPOP : S_GS_CK;
            S_GS_CK:   n_state = S_GS_RD;
            S_GPOP:    n_state = i_stat.q_empty ? S_GCHK : S_GTAKE;
            S_GTAKE:   n_state = S_GE;
            S_GE:      n_state = i_stat.e_done ? S_GPOP : S_GE_G;
            S_GE_G:    n_state = i_stat.range_skip ? S_GE : S_GE_R;
            S_GE_R:    n_state = i_stat.grp_skip ? S_GE : S_GE_W;
            S_GE_W:    n_state = S_GE;
            S_GCHK:    n_state = i_stat.cnt_ok_total ? S_KRD : S_FAIL;
            S_KRD:     n_state = i_stat.k_done ? S_EMIT_RD : S_KSET;
            S_KSET:    n_state = S_IS_RD;
            S_IS_RD:   n_state = i_stat.i_eq_n ? S_IPOP : S_IS_CK;
            S_IS_CK:   n_state = S_IS_RD;
            S_IPOP:    n_state = i_stat.q_empty ? S_ICHK : S_ITAKE;
            S_ITAKE:   n_state = S_IE;
            S_IE:      n_state = i_stat.e_done ? S_IPOP : S_IE_G;
            S_IE_G:    n_state = i_stat.it_skip ? S_IE : S_IE_R;
            S_IE_R:    n_state = i_stat.gid_b_ne_g ? S_IE : S_IE_W;
            S_IE_W:    n_state = S_IE;
            S_ICHK:    n_state = i_stat.cnt_ok_members ? S_KRD : S_FAIL;
            S_EMIT_RD: n_state = S_EMIT;
            S_EMIT: begin
                if (!i_stat.out_busy) n_state = i_stat.emit_last ? S_IDLE : S_EMIT_RD;
            end
            S_FAIL:    if (!i_stat.out_busy) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Drive datapath commands
    always_comb begin
        o_ready     = (r_state == S_IDLE);
        o_ctrl.load = i_valid && (r_state == S_IDLE);
        unique case (r_state)
            S_INIT:    o_ctrl.op = C_INIT;
            S_CLR:     o_ctrl.op = C_CLR;
            S_GID_RD:  o_ctrl.op = C_GID_RD;
            S_GID_WR:  o_ctrl.op = C_GID_WR;
            S_DEG_E:   o_ctrl.op = C_DEG_E;
            S_DEG_G:   o_ctrl.op = C_DEG_G;
            S_DEG_R:   o_ctrl.op = C_DEG_R;
            S_DEG_W:   o_ctrl.op = C_DEG_W;
            S_GS_RD:   o_ctrl.op = C_GS_RD;
            S_GS_CK:   o_ctrl.op = C_GS_CK;
            S_GPOP:    o_ctrl.op = C_GPOP;
            S_GTAKE:   o_ctrl.op = C_GTAKE;
            S_GE:      o_ctrl.op = C_GE;
            S_GE_G:    o_ctrl.op = C_GE_G;
            S_GE_R:    o_ctrl.op = C_GE_R;
            S_GE_W:    o_ctrl.op = C_GE_W;
            S_GCHK:    o_ctrl.op = C_GCHK;
            S_KRD:     o_ctrl.op = C_KRD;
            S_KSET:    o_ctrl.op = C_KSET;
            S_IS_RD:   o_ctrl.op = C_IS_RD;
            S_IS_CK:   o_ctrl.op = C_IS_CK;
            S_IPOP:    o_ctrl.op = C_IPOP;
            S_ITAKE:   o_ctrl.op = C_ITAKE;
            S_IE:      o_ctrl.op = C_IE;
            S_IE_G:    o_ctrl.op = C_IE_G;
            S_IE_R:    o_ctrl.op = C_IE_R;
            S_IE_W:    o_ctrl.op = C_IE_W;
            S_ICHK:    o_ctrl.op = C_ICHK;
            S_EMIT_RD: o_ctrl.op = C_EMIT_RD;
            S_EMIT:    o_ctrl.op = C_EMIT;
            S_FAIL:    o_ctrl.op = C_FAIL;
            default:   o_ctrl.op = C_NONE;
        endcase
    end

endmodule

/* design/gts_dp.sv */
// Datapath: tables, in-degree stores, ready queue, counters and result register.
`timescale 1ns / 1ps

module gts_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gts_pkg::t_ctrl                    i_ctrl,
    input  logic [1:0]                        i_opcode,
    input  logic [gts_pkg::ITEM_W-1:0]        i_item_index,
    input  logic [gts_pkg::SLOT_W-1:0]        i_group_index,
    input  logic [gts_pkg::ITEM_W-1:0]        i_before_item,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_addr,
    input  logic [gts_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                              i_out_ready,
    output gts_pkg::t_status                  o_stat,
    output logic                              o_out_valid,
    output logic [gts_pkg::ITEM_W-1:0]        o_out_item,
    output logic                              o_out_failed,
    output logic                              o_out_last
);
    import gts_pkg::*;

    // Memories
    logic [SLOT_W-1:0] grp_mem   [MAX_ITEMS];
    logic [EDGE_W-1:0] edge_mem  [MAX_EDGES];
    logic [SLOT_W-1:0] gid_mem   [MAX_ITEMS];
    logic [DEG_W-1:0]  gdeg_mem  [SLOTS];
    logic [DEG_W-1:0]  ideg_mem  [MAX_ITEMS];
    logic [SLOT_W-1:0] queue_mem [SLOTS];
    logic [SLOT_W-1:0] order_mem [SLOTS];
    logic [ITEM_W-1:0] seq_mem   [MAX_ITEMS];

    // Registered read data
    logic [SLOT_W-1:0] r_grp_q, r_gid_a, r_gid_b, r_q_q, r_ord_q;
    logic [EDGE_W-1:0] r_edge_q;
    logic [DEG_W-1:0]  r_gdeg_q, r_ideg_q;
    logic [ITEM_W-1:0] r_seq_q;

    // Control and working registers
    logic [CFG_W-1:0]  r_item_count, r_group_count;
    logic [ECNT_W-1:0] r_etot;
    logic              r_ovalid;
    logic [CFG_W-1:0]  r_n, n_n, r_m, n_m, r_members, n_members, r_prod, n_prod;
    logic [CNT_W-1:0]  r_total, n_total, r_i, n_i, r_head, n_head, r_tail, n_tail;
    logic [CNT_W-1:0]  r_cnt, n_cnt, r_k, n_k;
    logic [SLOT_W-1:0] r_next, n_next, r_g, n_g;
    logic [ITEM_W-1:0] r_d, n_d, r_u, n_u;
    logic [ECNT_W-1:0] r_e, n_e;
    logic              r_same, n_same;
    logic [ITEM_W-1:0] r_out_item;
    logic              r_out_failed, r_out_last;

    // Memory access controls
    logic              grp_re, edge_re, gid_rea, gid_reb, gdeg_re, ideg_re;
    logic              q_re, ord_re, seq_re;
    logic [ITEM_W-1:0] gid_addr_a, gid_addr_b, ideg_raddr, gid_waddr, ideg_waddr;
    logic [SLOT_W-1:0] gdeg_raddr, gdeg_waddr, q_raddr, q_wdata, gid_wdata;
    logic              gid_we, gdeg_we, ideg_we, q_we, ord_we, seq_we;
    logic [DEG_W-1:0]  gdeg_wdata, ideg_wdata;
    logic              out_load, out_fail;

    logic [ITEM_W-1:0] edge_b, edge_d;
    logic              range_skip, grp_skip, it_skip, out_busy, emit_last;
    logic              load_set, load_edge;

    assign edge_b     = r_edge_q[EDGE_W-1:ITEM_W];
    assign edge_d     = r_edge_q[ITEM_W-1:0];
    assign range_skip = ({1'b0, edge_b} >= r_n) || ({1'b0, edge_d} >= r_n);
    assign grp_skip   = (r_gid_a != r_g) || (r_gid_b == r_g);
    assign it_skip    = (edge_b != r_u) || ({1'b0, edge_d} >= r_n);
    assign out_busy   = r_ovalid && !i_out_ready;
    assign emit_last  = (r_i[CFG_W-1:0] == (r_prod - 7'd1));
    assign load_set   = i_ctrl.load && (i_opcode == OP_SET_GROUP);
    assign load_edge  = i_ctrl.load && (i_opcode == OP_ADD_EDGE)
                        && (r_etot < ECNT_W'(MAX_EDGES));

    // Report status
    always_comb begin
        o_stat.e_done         = (r_e == r_etot);
        o_stat.clr_last       = (r_i == CNT_W'(SLOTS - 1));
        o_stat.gid_last       = (r_i[CFG_W-1:0] == (r_n - 7'd1));
        o_stat.i_eq_total     = (r_i == r_total);
        o_stat.i_eq_n         = (r_i[CFG_W-1:0] == r_n);
        o_stat.q_empty        = (r_head == r_tail);
        o_stat.range_skip     = range_skip;
        o_stat.grp_skip       = grp_skip;
        o_stat.it_skip        = it_skip;
        o_stat.gid_b_ne_g     = (r_gid_b != r_g);
        o_stat.cnt_ok_total   = (r_cnt == r_total);
        o_stat.cnt_ok_members = (r_cnt == {1'b0, r_members});
        o_stat.k_done         = (r_k == r_total);
        o_stat.out_busy       = out_busy;
        o_stat.emit_last      = emit_last;
    end

    // Decode command into counter updates and memory accesses
    always_comb begin
        n_n = r_n; n_m = r_m; n_total = r_total; n_i = r_i; n_head = r_head;
        n_tail = r_tail; n_cnt = r_cnt; n_k = r_k; n_next = r_next; n_g = r_g;
        n_d = r_d; n_u = r_u; n_e = r_e; n_same = r_same;
        n_members = r_members; n_prod = r_prod;
        grp_re = 1'b0; edge_re = 1'b0; gid_rea = 1'b0; gid_reb = 1'b0;
        gdeg_re = 1'b0; ideg_re = 1'b0; q_re = 1'b0; ord_re = 1'b0; seq_re = 1'b0;
        gid_addr_a = edge_b; gid_addr_b = edge_d; ideg_raddr = r_d;
        gdeg_raddr = r_gid_b; q_raddr = r_head[SLOT_W-1:0];
        gid_we = 1'b0; gid_waddr = r_i[ITEM_W-1:0]; gid_wdata = r_next;
        gdeg_we = 1'b0; gdeg_waddr = r_gid_b; gdeg_wdata = '0;
        ideg_we = 1'b0; ideg_waddr = r_d; ideg_wdata = '0;
        q_we = 1'b0; q_wdata = r_gid_b; ord_we = 1'b0; seq_we = 1'b0;
        out_load = 1'b0; out_fail = 1'b0;
        case (i_ctrl.op) inside
            C_INIT: begin
                n_n     = (r_item_count == '0) ? 7'd1
                        : (r_item_count > CFG_W'(MAX_ITEMS)) ? CFG_W'(MAX_ITEMS)
                        : r_item_count;
                n_m     = (r_group_count > CFG_W'(MAX_GROUPS)) ? CFG_W'(MAX_GROUPS)
                        : r_group_count;
                n_total = {1'b0, n_n} + {1'b0, n_m};
                n_next  = n_m;
                n_i = '0; n_e = '0; n_head = '0; n_tail = '0; n_cnt = '0;
            end
            // Zero both in-degree stores
            C_CLR: begin
                gdeg_we    = 1'b1;
                gdeg_waddr = r_i[SLOT_W-1:0];
                ideg_we    = (r_i < CNT_W'(MAX_ITEMS));
                ideg_waddr = r_i[ITEM_W-1:0];
                n_i        = (r_i == CNT_W'(SLOTS - 1)) ? '0 : r_i + 8'd1;
            end
            C_GID_RD: grp_re = 1'b1;
            // Map each item to a declared or private group
            C_GID_WR: begin
                gid_we = 1'b1;
                if (r_grp_q < r_m) begin
                    gid_wdata = r_grp_q;
                end else begin
                    n_next = r_next + 7'd1;
                end
                n_i = (r_i[CFG_W-1:0] == (r_n - 7'd1)) ? '0 : r_i + 8'd1;
            end
            C_DEG_E, C_GE, C_IE: edge_re = 1'b1;
            C_DEG_G, C_GE_G: begin
                gid_rea = 1'b1; gid_reb = 1'b1; n_d = edge_d;
                if (range_skip) n_e = r_e + 9'd1;
            end
            C_DEG_R: begin
                n_same = (r_gid_a == r_gid_b);
                if (r_gid_a == r_gid_b) ideg_re = 1'b1;
                else gdeg_re = 1'b1;
            end
            // Count one edge into the right level
            C_DEG_W: begin
                if (r_same) begin
                    ideg_we = 1'b1; ideg_wdata = r_ideg_q + 9'd1;
                end else begin
                    gdeg_we = 1'b1; gdeg_wdata = r_gdeg_q + 9'd1;
                end
                n_e = r_e + 9'd1;
            end
            C_GS_RD: begin
                gdeg_re = 1'b1; gdeg_raddr = r_i[SLOT_W-1:0];
            end
            // Seed the queue with free groups
            C_GS_CK: begin
                if (r_gdeg_q == '0) begin
                    q_we = 1'b1; q_wdata = r_i[SLOT_W-1:0]; n_tail = r_tail + 8'd1;
                end
                n_i = r_i + 8'd1;
            end
            C_GPOP, C_IPOP: begin
                if (r_head != r_tail) begin
                    q_re = 1'b1; n_head = r_head + 8'd1;
                end
            end
            C_GTAKE: begin
                n_g = r_q_q; ord_we = 1'b1; n_cnt = r_cnt + 8'd1; n_e = '0;
            end
            C_GE_R: begin
                if (grp_skip) n_e = r_e + 9'd1;
                else gdeg_re = 1'b1;
            end
            // Release a successor group
            C_GE_W: begin
                if (r_gdeg_q != '0) begin
                    gdeg_we = 1'b1; gdeg_wdata = r_gdeg_q - 9'd1;
                    if (r_gdeg_q == 9'd1) begin
                        q_we = 1'b1; n_tail = r_tail + 8'd1;
                    end
                end
                n_e = r_e + 9'd1;
            end
            C_GCHK: begin
                n_k = '0; n_prod = '0;
            end
            C_KRD: begin
                if (r_k == r_total) n_i = '0;
                else ord_re = 1'b1;
            end
            C_KSET: begin
                n_g = r_ord_q; n_i = '0; n_head = '0; n_tail = '0;
                n_cnt = '0; n_members = '0;
            end
            C_IS_RD: begin
                gid_rea = 1'b1; gid_addr_a = r_i[ITEM_W-1:0];
                ideg_re = 1'b1; ideg_raddr = r_i[ITEM_W-1:0];
            end
            // Seed the queue with free members of this group
            C_IS_CK: begin
                if (r_gid_a == r_g) begin
                    n_members = r_members + 7'd1;
                    if (r_ideg_q == '0) begin
                        q_we = 1'b1; q_wdata = r_i[SLOT_W-1:0]; n_tail = r_tail + 8'd1;
                    end
                end
                n_i = r_i + 8'd1;
            end
            C_ITAKE: begin
                n_u = r_q_q[ITEM_W-1:0]; seq_we = 1'b1;
                n_prod = r_prod + 7'd1; n_cnt = r_cnt + 8'd1; n_e = '0;
            end
            C_IE_G: begin
                n_d = edge_d;
                if (it_skip) n_e = r_e + 9'd1;
                else gid_reb = 1'b1;
            end
            C_IE_R: begin
                if (r_gid_b != r_g) n_e = r_e + 9'd1;
                else ideg_re = 1'b1;
            end
            // Release a successor item
            C_IE_W: begin
                if (r_ideg_q != '0) begin
                    ideg_we = 1'b1; ideg_wdata = r_ideg_q - 9'd1;
                    if (r_ideg_q == 9'd1) begin
                        q_we = 1'b1; q_wdata = {1'b0, r_d}; n_tail = r_tail + 8'd1;
                    end
                end
                n_e = r_e + 9'd1;
            end
            C_ICHK: n_k = r_k + 8'd1;
            C_EMIT_RD: seq_re = 1'b1;
            C_EMIT: begin
                if (!out_busy) begin
                    out_load = 1'b1; n_i = r_i + 8'd1;
                end
            end
            C_FAIL: begin
                if (!out_busy) begin
                    out_load = 1'b1; out_fail = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Hold working registers
    always_ff @(posedge i_clk) begin
        r_n <= n_n; r_m <= n_m; r_total <= n_total; r_i <= n_i; r_head <= n_head;
        r_tail <= n_tail; r_cnt <= n_cnt; r_k <= n_k; r_next <= n_next; r_g <= n_g;
        r_d <= n_d; r_u <= n_u; r_e <= n_e; r_same <= n_same;
        r_members <= n_members; r_prod <= n_prod;
    end

    // Take configuration writes and load requests
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_count  <= 7'd1;
            r_group_count <= '0;
            r_etot        <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_addr == CFG_ITEM_COUNT))  r_item_count  <= i_cfg_wdata;
            if (i_cfg_we && (i_cfg_addr == CFG_GROUP_COUNT)) r_group_count <= i_cfg_wdata;
            if (i_ctrl.load && (i_opcode == OP_CLEAR)) r_etot <= '0;
            else if (load_edge) r_etot <= r_etot + 9'd1;
        end
    end

    // Write memories
    always_ff @(posedge i_clk) begin
        if (load_set)  grp_mem[i_item_index] <= i_group_index;
        if (load_edge) edge_mem[r_etot[EADDR_W-1:0]] <= {i_before_item, i_item_index};
        if (gid_we)    gid_mem[gid_waddr] <= gid_wdata;
        if (gdeg_we)   gdeg_mem[gdeg_waddr] <= gdeg_wdata;
        if (ideg_we)   ideg_mem[ideg_waddr] <= ideg_wdata;
        if (q_we)      queue_mem[r_tail[SLOT_W-1:0]] <= q_wdata;
        if (ord_we)    order_mem[r_cnt[SLOT_W-1:0]] <= r_q_q;
        if (seq_we)    seq_mem[r_prod[ITEM_W-1:0]] <= r_q_q[ITEM_W-1:0];
    end

    // Read memories
    always_ff @(posedge i_clk) begin
        if (grp_re)  r_grp_q  <= grp_mem[r_i[ITEM_W-1:0]];
        if (edge_re) r_edge_q <= edge_mem[r_e[EADDR_W-1:0]];
        if (gid_rea) r_gid_a  <= gid_mem[gid_addr_a];
        if (gid_reb) r_gid_b  <= gid_mem[gid_addr_b];
        if (gdeg_re) r_gdeg_q <= gdeg_mem[gdeg_raddr];
        if (ideg_re) r_ideg_q <= ideg_mem[ideg_raddr];
        if (q_re)    r_q_q    <= queue_mem[q_raddr];
        if (ord_re)  r_ord_q  <= order_mem[r_k[SLOT_W-1:0]];
        if (seq_re)  r_seq_q  <= seq_mem[r_i[ITEM_W-1:0]];
    end

    // Hold result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_item   <= out_fail ? '0 : r_seq_q;
            r_out_failed <= out_fail;
            r_out_last   <= out_fail | emit_last;
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_out_item   = r_out_item;
    assign o_out_failed = r_out_failed;
    assign o_out_last   = r_out_last;

endmodule

/* design/grouped_topological_sort.sv */
// Top level of the grouped topological sorter: stream ports, sequencer and datapath.
`timescale 1ns / 1ps

// Load requests (clear, set group, add edge) are taken while the sorter is idle. A
// start request orders the items with two-level Kahn ordering and then streams one
// result per item, or a single failure result if a cycle exists. The sort is paced
// by the one read port of the edge memory, which is walked once for the counts,
// once per group and once per item; the sort opens with a clearing pass over the
// in-degree stores. No request is taken during the sort.
module grouped_topological_sort (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // opcode[1:0], item_index[7:2], group_index[14:8], before_item[20:15], zero pad
    input  logic [23:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // ordered_item[5:0], zero pad
    output logic [7:0]  o_m_axis_tdata,
    // failed[0]
    output logic        o_m_axis_tuser,
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [6:0]  i_cfg_wdata
);
    import gts_pkg::*;

    t_ctrl             ctrl;
    t_status           stat;
    logic [ITEM_W-1:0] out_item;

    gts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_opcode (i_s_axis_tdata[1:0]),
        .i_stat   (stat),
        .o_ready  (o_s_axis_tready),
        .o_ctrl   (ctrl)
    );

    gts_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_opcode      (i_s_axis_tdata[1:0]),
        .i_item_index  (i_s_axis_tdata[7:2]),
        .i_group_index (i_s_axis_tdata[14:8]),
        .i_before_item (i_s_axis_tdata[20:15]),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_out_ready   (i_m_axis_tready),
        .o_stat        (stat),
        .o_out_valid   (o_m_axis_tvalid),
        .o_out_item    (out_item),
        .o_out_failed  (o_m_axis_tuser),
        .o_out_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {2'b00, out_item};

endmodule

/* sim/grouped_topological_sort_tb.sv */
// Self-checking testbench for the grouped topological sorter.
`timescale 1ns / 1ps

module grouped_topological_sort_tb;
    import gts_pkg::*;

    localparam int WATCHDOG_LIMIT = 400000;

    typedef struct {
        logic [5:0] item;
        logic       failed;
        logic       last;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [7:0]  o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        o_m_axis_tlast;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [6:0]  i_cfg_wdata;

    // Predictor state
    logic [6:0]  group_of_item [MAX_ITEMS];
    logic [11:0] dep_edges [MAX_EDGES];
    int          dep_edge_total;
    logic [6:0]  item_count_reg;
    logic [6:0]  group_count_reg;

    t_result     order_q [$];
    int          error_count;
    int          sort_count;
    int          result_count;
    int          request_count;
    int          stall_cycles;
    int          hold_cycles;
    bit          no_idle;

    grouped_topological_sort i_dut (.*);

    // Clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Print one mismatch and count it
    task automatic report_mismatch(string what, int exp_val, int got_val);
        $display("mismatch %0s: expected %0d, got %0d at %0t", what, exp_val, got_val, $time);
        error_count++;
    endtask

    // Compute the expected order of a start request
    task automatic predict_order();
        int n, m, total, nxt, head, tail, cnt, produced, members, b, d, g, u;
        int gid [MAX_ITEMS];
        int gdeg [SLOTS];
        int ideg [MAX_ITEMS];
        int ready [SLOTS];
        int gord [SLOTS];
        int seq [MAX_ITEMS];
        int raw;
        t_result r;
        n = item_count_reg;
        m = group_count_reg;
        if (n < 1) n = 1;
        if (n > MAX_ITEMS) n = MAX_ITEMS;
        if (m > MAX_GROUPS) m = MAX_GROUPS;
        total = n + m;
        nxt = m;
        produced = 0;
        for (int i = 0; i < n; i++) begin
            raw = group_of_item[i];
            if (raw < 64 && raw < m) gid[i] = raw;
            else gid[i] = nxt++;
        end
        for (int i = 0; i < SLOTS; i++) gdeg[i] = 0;
        for (int i = 0; i < MAX_ITEMS; i++) ideg[i] = 0;
        for (int e = 0; e < dep_edge_total; e++) begin
            b = dep_edges[e][11:6];
            d = dep_edges[e][5:0];
            if (b >= n || d >= n) continue;
            if (gid[b] == gid[d]) ideg[d]++;
            else gdeg[gid[d]]++;
        end
        // Group level
        head = 0; tail = 0; cnt = 0;
        for (int i = 0; i < total; i++)
            if (gdeg[i] == 0) ready[tail++] = i;
        while (head < tail) begin
            g = ready[head++];
            gord[cnt++] = g;
            for (int e = 0; e < dep_edge_total; e++) begin
                b = dep_edges[e][11:6];
                d = dep_edges[e][5:0];
                if (b >= n || d >= n || gid[b] != g || gid[d] == g) continue;
                if (gdeg[gid[d]] > 0) begin
                    gdeg[gid[d]]--;
                    if (gdeg[gid[d]] == 0) ready[tail++] = gid[d];
                end
            end
        end
        r.item = '0; r.failed = 1'b1; r.last = 1'b1;
        if (cnt != total) begin
            order_q.push_back(r);
            return;
        end
        // Item level, one group at a time
        for (int k = 0; k < total; k++) begin
            g = gord[k];
            members = 0; head = 0; tail = 0; cnt = 0;
            for (int i = 0; i < n; i++) begin
                if (gid[i] != g) continue;
                members++;
                if (ideg[i] == 0) ready[tail++] = i;
            end
            while (head < tail) begin
                u = ready[head++];
                cnt++;
                seq[produced++] = u;
                for (int e = 0; e < dep_edge_total; e++) begin
                    b = dep_edges[e][11:6];
                    d = dep_edges[e][5:0];
                    if (b != u || d >= n || gid[d] != g) continue;
                    if (ideg[d] > 0) begin
                        ideg[d]--;
                        if (ideg[d] == 0) ready[tail++] = d;
                    end
                end
            end
            if (cnt != members) begin
                order_q.push_back(r);
                return;
            end
        end
        for (int i = 0; i < produced; i++) begin
            r.item = seq[i][5:0];
            r.failed = 1'b0;
            r.last = (i + 1 == produced);
            order_q.push_back(r);
        end
    endtask

    // Apply an accepted request to the predictor
    task automatic apply_request(t_op op, logic [5:0] item, logic [6:0] grp,
                                 logic [5:0] before_it);
        case (op)
            OP_CLEAR: begin
                for (int i = 0; i < MAX_ITEMS; i++) group_of_item[i] = '0;
                dep_edge_total = 0;
            end
            OP_SET_GROUP: group_of_item[item] = grp;
            OP_ADD_EDGE: begin
                if (dep_edge_total < MAX_EDGES) dep_edges[dep_edge_total++] = {before_it, item};
            end
            default: begin
                predict_order();
                sort_count++;
            end
        endcase
    endtask

    // Send one request; entered and left at a falling edge
    task automatic send_request(t_op op, logic [5:0] item, logic [6:0] grp,
                                logic [5:0] before_it);
        if (!no_idle && $urandom_range(99) < 27) begin
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_s_axis_tdata  = {3'b000, before_it, grp, item, op};
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        apply_request(op, item, grp, before_it);
        request_count++;
        @(negedge i_clk);
    endtask

    // Wait for all results, let the block settle, then write a register
    task automatic write_config(logic addr, logic [6:0] value);
        i_s_axis_tvalid = 1'b0;
        while (order_q.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = addr;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (addr == CFG_ITEM_COUNT) item_count_reg = value;
        else group_count_reg = value;
    endtask

    task automatic set_sizes(logic [6:0] n, logic [6:0] m);
        write_config(CFG_ITEM_COUNT, n);
        write_config(CFG_GROUP_COUNT, m);
    endtask

    // Small hand-built cases: single item, cross/inner edges, cycles, duplicates
    task automatic test_directed();
        send_request(OP_SET_GROUP, 6'd0, 7'h7F, 6'd0);
        send_request(OP_START, 6'd0, 7'd0, 6'd0);
        set_sizes(7'd4, 7'd2);
        send_request(OP_CLEAR, 6'd0, 7'd0, 6'd0);
        send_request(OP_SET_GROUP, 6'd0, 7'd1, 6'd0);
        send_request(OP_SET_GROUP, 6'd1, 7'd0, 6'd0);
        send_request(OP_SET_GROUP, 6'd2, 7'h7F, 6'd0);
        send_request(OP_SET_GROUP, 6'd3, 7'd5, 6'd0);
        send_request(OP_ADD_EDGE, 6'd1, 7'd0, 6'd3);
        send_request(OP_ADD_EDGE, 6'd0, 7'd0, 6'd2);
        send_request(OP_ADD_EDGE, 6'd0, 7'd0, 6'd2);
        send_request(OP_ADD_EDGE, 6'd63, 7'd0, 6'd63);
        send_request(OP_START, 6'd0, 7'd0, 6'd0);
        // self edge is a cycle
        send_request(OP_ADD_EDGE, 6'd2, 7'd0, 6'd2);
        send_request(OP_START, 6'd0, 7'd0, 6'd0);
        // group-level cycle
        send_request(OP_CLEAR, 6'd0, 7'd0, 6'd0);
        for (int i = 0; i < 4; i++) send_request(OP_SET_GROUP, i[5:0], i[6:0] & 7'd1, 6'd0);
        send_request(OP_ADD_EDGE, 6'd1, 7'd0, 6'd0);
        send_request(OP_ADD_EDGE, 6'd2, 7'd0, 6'd1);
        send_request(OP_START, 6'd0, 7'd0, 6'd0);
    endtask

    // Register saturation, the largest sizes and a full edge table
    task automatic test_extremes();
        set_sizes(7'd0, 7'd0);
        send_request(OP_START, 6'd0, 7'd0, 6'd0);
        set_sizes(7'd127, 7'd100);
        send_request(OP_CLEAR, 6'd0, 7'd0, 6'd0);
        for (int i = 0; i < MAX_ITEMS; i++)
            send_request(OP_SET_GROUP, i[5:0], 7'(i % 70), 6'd0);
        for (int i = 0; i < 10; i++)
            send_request(OP_ADD_EDGE, 6'(63 - i), 7'd0, 6'(62 - i));
        send_request(OP_START, 6'd0, 7'd0, 6'd0);
        set_sizes(7'd2, 7'd64);
        send_request(OP_CLEAR, 6'd0, 7'd0, 6'd0);
        send_request(OP_SET_GROUP, 6'd0, 7'd63, 6'd0);
        send_request(OP_SET_GROUP, 6'd1, 7'd63, 6'd0);
        for (int i = 0; i < MAX_EDGES + 4; i++)
            send_request(OP_ADD_EDGE, 6'd1, 7'd0, 6'd0);
        send_request(OP_START, 6'd0, 7'd0, 6'd0);
        // an edge past the full table would close a cycle
        send_request(OP_ADD_EDGE, 6'd0, 7'd0, 6'd1);
        send_request(OP_START, 6'd0, 7'd0, 6'd0);
    endtask

    // Load one random problem and start it
    task automatic load_random_problem(int n, int m, bit well_formed);
        int g, ne, b, d;
        logic [6:0] grp;
        send_request(OP_CLEAR, 6'($urandom), 7'($urandom), 6'($urandom));
        g = 0;
        for (int i = 0; i < n; i++) begin
            if (well_formed) begin
                if ($urandom_range(3) == 0) grp = 7'h7F;
                else begin
                    if ($urandom_range(2) == 0) g++;
                    grp = 7'(g);
                end
            end else begin
                case ($urandom_range(3))
                    0: grp = 7'h7F;
                    1: grp = 7'($urandom_range(63));
                    default: grp = 7'($urandom_range(m > 0 ? m - 1 : 0));
                endcase
            end
            send_request(OP_SET_GROUP, i[5:0], grp, 6'($urandom));
        end
        if ($urandom_range(3) == 0)
            send_request(OP_SET_GROUP, 6'($urandom_range(63)), 7'($urandom), 6'($urandom));
        ne = $urandom_range(0, 2 * n);
        for (int e = 0; e < ne; e++) begin
            b = $urandom_range(n - 1);
            d = $urandom_range(n - 1);
            if (well_formed && n > 1) begin
                if (b == d) d = (b + 1) % n;
                if (b > d) begin
                    g = b; b = d; d = g;
                end
            end else if ($urandom_range(7) == 0) begin
                b = $urandom_range(63);
            end
            send_request(OP_ADD_EDGE, 6'(d), 7'($urandom), 6'(b));
        end
        send_request(OP_START, 6'($urandom), 7'($urandom), 6'($urandom));
    endtask

    // Random problems, mostly well-formed, small sizes with a few larger ones
    task automatic test_random();
        int n, m, start_count;
        start_count = request_count;
        while (request_count - start_count < 210) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            m = $urandom_range(0, 5);
            no_idle = ($urandom_range(5) == 0);
            set_sizes(7'(n), 7'(m));
            load_random_problem(n, m, $urandom_range(9) < 7);
        end
        no_idle = 1'b0;
    endtask

    // Hold the receiver off while starts and loads keep coming
    task automatic test_backpressure();
        set_sizes(7'd16, 7'd3);
        @(negedge i_clk);
        hold_cycles = 12000;
        load_random_problem(16, 3, 1'b1);
        load_random_problem(16, 3, 1'b1);
    endtask

    // Receiver ready: random idling, long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_m_axis_tready = 1'b0;
        end else begin
            i_m_axis_tready = no_idle || ($urandom_range(99) >= 27);
        end
    end

    // Check each result against the oldest expectation
    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            result_count++;
            if (order_q.size() == 0) begin
                report_mismatch("unexpected result item", -1, int'(o_m_axis_tdata));
            end else begin
                r = order_q.pop_front();
                if (o_m_axis_tdata !== {2'b00, r.item})
                    report_mismatch("ordered_item", r.item, o_m_axis_tdata);
                if (o_m_axis_tuser !== r.failed)
                    report_mismatch("failed", r.failed, o_m_axis_tuser);
                if (o_m_axis_tlast !== r.last)
                    report_mismatch("last", r.last, o_m_axis_tlast);
            end
        end
    end

    // Stop on a long stretch with no accepted request or result
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            stall_cycles = 0;
        else if (++stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = 1'b0;
        i_cfg_wdata     = '0;
        error_count = 0; sort_count = 0; result_count = 0; request_count = 0;
        stall_cycles = 0; hold_cycles = 0; no_idle = 1'b0;
        item_count_reg = 7'd1;
        group_count_reg = 7'd0;
        dep_edge_total = 0;
        for (int i = 0; i < MAX_ITEMS; i++) group_of_item[i] = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_extremes();
        test_backpressure();
        test_random();

        i_s_axis_tvalid = 1'b0;
        while (order_q.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        $display("covered %0d requests and %0d sorts, %0d results checked", request_count,
                 sort_count, result_count);
        $display("including cycles, saturated sizes, a full edge table and a long hold-off");
        if (error_count == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
design/gts_pkg.sv
design/gts_ctrl.sv
design/gts_dp.sv
design/grouped_topological_sort.sv
sim/grouped_topological_sort_tb.sv
